// ===== sv/hcsu_pkg.sv =====
// Shared types and constants for the hyperbolic cyclic stress update unit.
// No dependencies; every other file but hcsu_div refers to it by scoped names.
package hcsu_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHEAR_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHEAR_STRESS  = 1'b1;

    localparam logic [DATA_W-1:0] RST_MODULUS  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] RST_STRENGTH = 32'h0001_0000;

    localparam logic CMD_TRIAL  = 1'b0;
    localparam logic CMD_COMMIT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_DIST, S_MX, S_MGT, S_MN0, S_MN1, S_MNA,
        S_DIVM, S_WAITM, S_STRESS, S_DIVR, S_WAITR, S_RATIO,
        S_MP0, S_MP1, S_MT0, S_MT1, S_MT2, S_TAN, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_COMMIT, OP_LATCH, OP_PREP, OP_DIST, OP_MX, OP_MGT,
        OP_MN0, OP_MN1, OP_MNA, OP_DIVM, OP_STRESS, OP_DIVR, OP_RATIO,
        OP_MP0, OP_MP1, OP_MT0, OP_MT1, OP_MT2, OP_TAN, OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

// ===== sv/hcsu_in_if.sv =====
// Input channel: valid/ready handshake carrying one command transaction.
// Depends on hcsu_pkg for the data width.
interface hcsu_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic signed [hcsu_pkg::DATA_W-1:0] strain_increment;

    modport source (output valid, output cmd, output strain_increment, input ready);
    modport sink   (input valid, input cmd, input strain_increment, output ready);
endinterface

// ===== sv/hcsu_out_if.sv =====
// Output channel: valid/ready handshake carrying one result transaction.
// Depends on hcsu_pkg for the data width.
interface hcsu_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [hcsu_pkg::DATA_W-1:0] stress;
    logic        [hcsu_pkg::DATA_W-1:0] tangent;
    logic                              on_reversal_branch;

    modport source (output valid, output stress, output tangent,
                    output on_reversal_branch, input ready);
    modport sink   (input valid, input stress, input tangent,
                    input on_reversal_branch, output ready);
endinterface

// ===== sv/hcsu_div.sv =====
// Iterative 128-by-64 restoring divider, two quotient bits per cycle.
// Saturates to all ones when the quotient exceeds 64 bits. Uses hcsu_pkg nothing.
module hcsu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_hi,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_quot, n_quot;
    logic [63:0] r_den;
    logic [63:0] w_rem1, w_rem2;
    logic        w_q1, w_q2;

    function automatic logic [64:0] f_step(input logic [63:0] rem, input logic bit_in,
                                           input logic [63:0] den);
        logic [64:0] sh;
        logic [64:0] df;
        sh = {rem, bit_in};
        df = sh - {1'b0, den};
        if (sh >= {1'b0, den}) begin
            return {1'b1, df[63:0]};
        end
        return {1'b0, sh[63:0]};
    endfunction

    always_comb begin
        {w_q1, w_rem1} = f_step(r_rem, r_lo[63], r_den);
        {w_q2, w_rem2} = f_step(w_rem1, r_lo[62], r_den);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_quot = r_quot;
        if (i_start) begin
            if (i_hi >= i_den) begin
                n_quot = '1;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_rem  = i_hi;
                n_lo   = i_lo;
                n_quot = '0;
                n_cnt  = '1;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem  = w_rem2;
            n_lo   = {r_lo[61:0], 2'b00};
            n_quot = {r_quot[61:0], w_q1, w_q2};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_lo   <= n_lo;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/hcsu_ctrl.sv =====
// Controller state machine: sequences the datapath and owns both handshakes.
// Depends on hcsu_pkg for states, datapath operations and status.
module hcsu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hcsu_pkg::t_dp_cmd o_cmd,
    input  hcsu_pkg::t_dp_sts i_sts
);

    hcsu_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_load;

    assign w_load = (r_state == hcsu_pkg::S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcsu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == hcsu_pkg::CMD_COMMIT) ? hcsu_pkg::S_FIN
                                                                 : hcsu_pkg::S_PREP;
                end
            end
            hcsu_pkg::S_PREP:   n_state = hcsu_pkg::S_DIST;
            hcsu_pkg::S_DIST:   n_state = hcsu_pkg::S_MX;
            hcsu_pkg::S_MX:     n_state = hcsu_pkg::S_MGT;
            hcsu_pkg::S_MGT:    n_state = hcsu_pkg::S_MN0;
            hcsu_pkg::S_MN0:    n_state = hcsu_pkg::S_MN1;
            hcsu_pkg::S_MN1:    n_state = hcsu_pkg::S_MNA;
            hcsu_pkg::S_MNA:    n_state = hcsu_pkg::S_DIVM;
            hcsu_pkg::S_DIVM:   n_state = hcsu_pkg::S_WAITM;
            hcsu_pkg::S_WAITM: begin
                if (i_sts.div_done) begin
                    n_state = hcsu_pkg::S_STRESS;
                end
            end
            hcsu_pkg::S_STRESS: n_state = hcsu_pkg::S_DIVR;
            hcsu_pkg::S_DIVR:   n_state = hcsu_pkg::S_WAITR;
            hcsu_pkg::S_WAITR: begin
                if (i_sts.div_done) begin
                    n_state = hcsu_pkg::S_RATIO;
                end
            end
            hcsu_pkg::S_RATIO:  n_state = hcsu_pkg::S_MP0;
            hcsu_pkg::S_MP0:    n_state = hcsu_pkg::S_MP1;
            hcsu_pkg::S_MP1:    n_state = hcsu_pkg::S_MT0;
            hcsu_pkg::S_MT0:    n_state = hcsu_pkg::S_MT1;
            hcsu_pkg::S_MT1:    n_state = hcsu_pkg::S_MT2;
            hcsu_pkg::S_MT2:    n_state = hcsu_pkg::S_TAN;
            hcsu_pkg::S_TAN:    n_state = hcsu_pkg::S_FIN;
            hcsu_pkg::S_FIN: begin
                if (w_load) begin
                    n_state = hcsu_pkg::S_IDLE;
                end
            end
            default:            n_state = hcsu_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op = hcsu_pkg::OP_NONE;
        unique case (r_state)
            hcsu_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = (i_in_cmd == hcsu_pkg::CMD_COMMIT) ? hcsu_pkg::OP_COMMIT
                                                                  : hcsu_pkg::OP_LATCH;
                end
            end
            hcsu_pkg::S_PREP:   o_cmd.op = hcsu_pkg::OP_PREP;
            hcsu_pkg::S_DIST:   o_cmd.op = hcsu_pkg::OP_DIST;
            hcsu_pkg::S_MX:     o_cmd.op = hcsu_pkg::OP_MX;
            hcsu_pkg::S_MGT:    o_cmd.op = hcsu_pkg::OP_MGT;
            hcsu_pkg::S_MN0:    o_cmd.op = hcsu_pkg::OP_MN0;
            hcsu_pkg::S_MN1:    o_cmd.op = hcsu_pkg::OP_MN1;
            hcsu_pkg::S_MNA:    o_cmd.op = hcsu_pkg::OP_MNA;
            hcsu_pkg::S_DIVM:   o_cmd.op = hcsu_pkg::OP_DIVM;
            hcsu_pkg::S_WAITM:  o_cmd.op = hcsu_pkg::OP_NONE;
            hcsu_pkg::S_STRESS: o_cmd.op = hcsu_pkg::OP_STRESS;
            hcsu_pkg::S_DIVR:   o_cmd.op = hcsu_pkg::OP_DIVR;
            hcsu_pkg::S_WAITR:  o_cmd.op = hcsu_pkg::OP_NONE;
            hcsu_pkg::S_RATIO:  o_cmd.op = hcsu_pkg::OP_RATIO;
            hcsu_pkg::S_MP0:    o_cmd.op = hcsu_pkg::OP_MP0;
            hcsu_pkg::S_MP1:    o_cmd.op = hcsu_pkg::OP_MP1;
            hcsu_pkg::S_MT0:    o_cmd.op = hcsu_pkg::OP_MT0;
            hcsu_pkg::S_MT1:    o_cmd.op = hcsu_pkg::OP_MT1;
            hcsu_pkg::S_MT2:    o_cmd.op = hcsu_pkg::OP_MT2;
            hcsu_pkg::S_TAN:    o_cmd.op = hcsu_pkg::OP_TAN;
            hcsu_pkg::S_FIN: begin
                if (w_load) begin
                    o_cmd.op = hcsu_pkg::OP_OUT;
                end
            end
            default:            o_cmd.op = hcsu_pkg::OP_NONE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcsu_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == hcsu_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/hcsu_dp.sv =====
// Datapath: configuration, material state, shared 32x32 multiplier and divider.
// Depends on hcsu_pkg and hcsu_div; driven by operations from hcsu_ctrl.
module hcsu_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hcsu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [hcsu_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic signed [hcsu_pkg::DATA_W-1:0]  i_strain_increment,
    input  hcsu_pkg::t_dp_cmd                   i_cmd,
    output hcsu_pkg::t_dp_sts                   o_sts,
    output logic signed [hcsu_pkg::DATA_W-1:0]  o_stress,
    output logic [hcsu_pkg::DATA_W-1:0]         o_tangent,
    output logic                                o_on_reversal_branch
);

    logic [31:0]        r_g, r_t;
    logic signed [31:0] r_de;
    logic signed [31:0] r_cstrain, r_cstress, r_rstrain, r_rstress, r_tstrain, r_tstress;
    logic [31:0]        r_tan;
    logic               r_seen;
    logic [31:0]        r_k;
    logic               r_neg;
    logic signed [31:0] r_base;
    logic [63:0]        r_prod, r_x, r_gt, r_den, r_p;
    logic [95:0]        r_num;
    logic [96:0]        r_acc;
    logic [32:0]        r_ratio;
    logic signed [31:0] r_out_stress;
    logic [31:0]        r_out_tangent;
    logic               r_out_rev;

    logic [31:0]        w_teff;
    logic signed [32:0] w_sum;
    logic signed [33:0] w_probe;
    logic               w_rev;
    logic signed [31:0] w_tstrain;
    logic signed [31:0] w_ref;
    logic signed [32:0] w_dist, w_abs;
    logic [31:0]        w_ma, w_mb;
    logic [63:0]        w_mul;
    logic               w_div_start;
    logic [63:0]        w_div_hi, w_div_lo, w_quot;
    logic               w_div_done;
    logic [40:0]        w_mag;
    logic signed [42:0] w_st;
    logic signed [31:0] w_st_sat;
    logic [32:0]        w_ratio;

    assign w_teff = (r_t == '0) ? 32'd1 : r_t;

    always_comb begin
        w_sum   = 33'(r_cstrain) + 33'(r_de);
        w_probe = 34'(w_sum) - 34'(r_rstrain);
        w_rev   = (w_probe < 0 && r_de > 0) || (w_probe > 0 && r_de < 0);
        if (w_sum > 33'sd2147483647) begin
            w_tstrain = 32'sh7FFF_FFFF;
        end else if (w_sum < -33'sd2147483648) begin
            w_tstrain = 32'sh8000_0000;
        end else begin
            w_tstrain = w_sum[31:0];
        end
        w_ref  = r_seen ? r_rstrain : 32'sd0;
        w_dist = 33'(r_tstrain) - 33'(w_ref);
        w_abs  = (w_dist < 0) ? -w_dist : w_dist;
    end

    always_comb begin
        w_ma = r_g;
        w_mb = r_k;
        case (i_cmd.op)
            hcsu_pkg::OP_MGT: begin
                w_ma = r_g;
                w_mb = w_teff;
            end
            hcsu_pkg::OP_MN0: begin
                w_ma = r_prod[31:0];
                w_mb = r_k;
            end
            hcsu_pkg::OP_MN1: begin
                w_ma = r_gt[63:32];
                w_mb = r_k;
            end
            hcsu_pkg::OP_MP0: begin
                w_ma = r_g;
                w_mb = r_ratio[31:0];
            end
            hcsu_pkg::OP_MT0: begin
                w_ma = r_p[31:0];
                w_mb = r_ratio[31:0];
            end
            hcsu_pkg::OP_MT1: begin
                w_ma = r_p[63:32];
                w_mb = r_ratio[31:0];
            end
            default: begin
                w_ma = r_g;
                w_mb = r_k;
            end
        endcase
        w_mul = 64'(w_ma) * 64'(w_mb);
    end

    always_comb begin
        w_div_start = (i_cmd.op == hcsu_pkg::OP_DIVM) || (i_cmd.op == hcsu_pkg::OP_DIVR);
        if (i_cmd.op == hcsu_pkg::OP_DIVR) begin
            w_div_hi = {33'd0, w_teff[31:1]};
            w_div_lo = {w_teff[0], 63'd0};
        end else begin
            w_div_hi = {32'd0, r_num[95:64]};
            w_div_lo = r_num[63:0];
        end
    end

    hcsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_hi    (w_div_hi),
        .i_lo    (w_div_lo),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_sts.div_done = w_div_done;

    always_comb begin
        w_mag = (w_quot > 64'h100_0000_0000) ? 41'h100_0000_0000 : w_quot[40:0];
        if (r_neg) begin
            w_st = 43'(r_base) - $signed({2'b00, w_mag});
        end else begin
            w_st = 43'(r_base) + $signed({2'b00, w_mag});
        end
        if (w_st > 43'sd2147483647) begin
            w_st_sat = 32'sh7FFF_FFFF;
        end else if (w_st < -43'sd2147483648) begin
            w_st_sat = 32'sh8000_0000;
        end else begin
            w_st_sat = w_st[31:0];
        end
        w_ratio = (w_quot > 64'h1_0000_0000) ? 33'h1_0000_0000 : w_quot[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g       <= hcsu_pkg::RST_MODULUS;
            r_t       <= hcsu_pkg::RST_STRENGTH;
            r_cstrain <= '0;
            r_cstress <= '0;
            r_rstrain <= '0;
            r_rstress <= '0;
            r_tstrain <= '0;
            r_tstress <= '0;
            r_tan     <= hcsu_pkg::RST_MODULUS;
            r_seen    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hcsu_pkg::CFG_MAX_SHEAR_MODULUS: r_g <= i_cfg_data;
                    hcsu_pkg::CFG_MAX_SHEAR_STRESS:  r_t <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                hcsu_pkg::OP_COMMIT: begin
                    r_cstrain <= r_tstrain;
                    r_cstress <= r_tstress;
                end
                hcsu_pkg::OP_PREP: begin
                    if (w_rev) begin
                        r_rstrain <= r_cstrain;
                        r_rstress <= r_cstress;
                        r_seen    <= 1'b1;
                    end
                    r_tstrain <= w_tstrain;
                end
                hcsu_pkg::OP_STRESS: r_tstress <= w_st_sat;
                hcsu_pkg::OP_TAN:    r_tan     <= r_acc[95:64];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            hcsu_pkg::OP_LATCH: r_de <= i_strain_increment;
            hcsu_pkg::OP_DIST: begin
                r_k    <= w_abs[31:0];
                r_neg  <= (w_dist < 0);
                r_base <= r_seen ? r_rstress : 32'sd0;
            end
            hcsu_pkg::OP_MX:  r_prod <= w_mul;
            hcsu_pkg::OP_MGT: begin
                r_x    <= r_seen ? {1'b0, r_prod[63:1]} : r_prod;
                r_prod <= w_mul;
            end
            hcsu_pkg::OP_MN0: begin
                r_gt   <= r_prod;
                r_prod <= w_mul;
                r_den  <= {1'b0, w_teff, 31'd0} + r_x;
            end
            hcsu_pkg::OP_MN1: begin
                r_num  <= {32'd0, r_prod};
                r_prod <= w_mul;
            end
            hcsu_pkg::OP_MNA: r_num <= r_num + {r_prod, 32'd0};
            hcsu_pkg::OP_RATIO: r_ratio <= w_ratio;
            hcsu_pkg::OP_MP0: r_prod <= w_mul;
            hcsu_pkg::OP_MP1: r_p <= r_prod + (r_ratio[32] ? {r_g, 32'd0} : 64'd0);
            hcsu_pkg::OP_MT0: r_prod <= w_mul;
            hcsu_pkg::OP_MT1: begin
                r_acc  <= {33'd0, r_prod};
                r_prod <= w_mul;
            end
            hcsu_pkg::OP_MT2: begin
                r_acc <= r_acc + {1'b0, r_prod, 32'd0}
                         + (r_ratio[32] ? {1'b0, r_p, 32'd0} : 97'd0);
            end
            hcsu_pkg::OP_OUT: begin
                r_out_stress  <= r_tstress;
                r_out_tangent <= r_tan;
                r_out_rev     <= r_seen;
            end
            default: ;
        endcase
    end

    assign o_stress             = r_out_stress;
    assign o_tangent            = r_out_tangent;
    assign o_on_reversal_branch = r_out_rev;

endmodule

// ===== sv/hyperbolic_cyclic_stress_update_unit.sv =====
// Top level of the hyperbolic cyclic stress update unit (Masing rule).
// Depends on hcsu_pkg, hcsu_in_if, hcsu_out_if, hcsu_ctrl, hcsu_dp, hcsu_div.
//
//   channel  | dir | handshake         | payload
//   i_in     | in  | valid/ready       | cmd, strain_increment
//   o_out    | out | valid/ready       | stress, tangent, on_reversal_branch
//   cfg      | in  | i_cfg_we only     | i_cfg_idx, i_cfg_data
//
// A trial runs two passes of the shared 2-bit-per-cycle divider plus the
// multiply sequence; a commit goes from idle straight to the final step.
// One transaction is in flight at a time. A finished result waits in the
// output register; a stalled output holds the unit in its last step.
// Synchronous active-low reset restores config, material and control state.
module hyperbolic_cyclic_stress_update_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hcsu_in_if.sink                        i_in,
    hcsu_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [hcsu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hcsu_pkg::DATA_W-1:0]    i_cfg_data
);

    hcsu_pkg::t_dp_cmd w_cmd;
    hcsu_pkg::t_dp_sts w_sts;

    hcsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    hcsu_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_strain_increment   (i_in.strain_increment),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .o_stress             (o_out.stress),
        .o_tangent            (o_out.tangent),
        .o_on_reversal_branch (o_out.on_reversal_branch)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for hyperbolic_cyclic_stress_update_unit.
// Depends on hcsu_pkg, hcsu_in_if and hcsu_out_if; a scoreboard class predicts
// each result of the Masing-rule stress update and checks it in order.
module tb;

    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] stress;
        logic [31:0]        tangent;
        logic               on_rev;
    } t_stress_result;

    class t_stress_scoreboard;
        logic [31:0]        modulus;
        logic [31:0]        strength;
        logic signed [63:0] com_strain, com_stress, rev_strain, rev_stress;
        logic signed [63:0] trial_strain, trial_stress;
        logic [31:0]        tangent;
        bit                 rev_seen;
        t_stress_result     expected_q[$];
        int                 errors;

        function new();
            modulus = hcsu_pkg::RST_MODULUS;
            strength = hcsu_pkg::RST_STRENGTH;
            com_strain = 0; com_stress = 0; rev_strain = 0; rev_stress = 0;
            trial_strain = 0; trial_stress = 0;
            tangent = hcsu_pkg::RST_MODULUS;
            rev_seen = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [hcsu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == hcsu_pkg::CFG_MAX_SHEAR_MODULUS) modulus = val;
            else if (idx == hcsu_pkg::CFG_MAX_SHEAR_STRESS) strength = val;
        endfunction

        function logic signed [63:0] clamp32(logic signed [63:0] v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function logic [63:0] div_sat(logic [127:0] num, logic [63:0] den);
            logic [127:0] q;
            if (den == 0) return '1;
            q = num / {64'd0, den};
            if (q[127:64] != 0) return '1;
            return q[63:0];
        endfunction

        function void note_input(logic cmd, logic [31:0] de);
            logic signed [63:0] de64, probe, span, base;
            logic [63:0]        g, t, k, x, tq, den, gt, mag, ratio, gr;
            logic [127:0]       prod;
            t_stress_result     r;
            if (cmd == hcsu_pkg::CMD_COMMIT) begin
                com_strain = trial_strain;
                com_stress = trial_stress;
                r.stress = com_stress[31:0];
            end else begin
                de64 = {{32{de[31]}}, de};
                probe = com_strain + de64 - rev_strain;
                if ((probe < 0 && de64 > 0) || (probe > 0 && de64 < 0)) begin
                    rev_strain = com_strain;
                    rev_stress = com_stress;
                    rev_seen = 1;
                end
                trial_strain = clamp32(com_strain + de64);
                span = rev_seen ? trial_strain - rev_strain : trial_strain;
                base = rev_seen ? rev_stress : 64'sd0;
                k = (span < 0) ? -span : span;
                g = {32'd0, modulus};
                t = (strength == 0) ? 64'd1 : {32'd0, strength};
                x = g * k;
                if (rev_seen) x = x >> 1;
                tq = t << 31;
                den = tq + x;
                gt = g * t;
                prod = {64'd0, gt} * {64'd0, k};
                mag = div_sat(prod, den);
                if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
                trial_stress = clamp32(span < 0 ? base - $signed(mag) : base + $signed(mag));
                ratio = div_sat({64'd0, tq} << 32, den);
                if (ratio > (64'd1 << 32)) ratio = 64'd1 << 32;
                gr = g * ratio;
                prod = {64'd0, gr} * {64'd0, ratio};
                tangent = prod[95:64];
                r.stress = trial_stress[31:0];
            end
            r.tangent = tangent;
            r.on_rev = rev_seen;
            expected_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("stress update: %s got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] stress, logic [31:0] tan, logic on_rev);
            t_stress_result e;
            if (expected_q.size() == 0) begin
                report("unexpected transaction, stress", stress, 32'd0);
                return;
            end
            e = expected_q.pop_front();
            if (stress !== e.stress) report("stress", stress, e.stress);
            if (tan !== e.tangent) report("tangent", tan, e.tangent);
            if (on_rev !== e.on_rev) report("on_reversal_branch", on_rev, e.on_rev);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [hcsu_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [hcsu_pkg::DATA_W-1:0] i_cfg_data;

    hcsu_in_if  in_ch();
    hcsu_out_if out_ch();

    hyperbolic_cyclic_stress_update_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_stress_scoreboard sb = new();
    bit no_idle = 0;
    bit hold_req = 0;
    int hold_cycles = 0;
    int unsigned cycle_count = 0;
    int direction = 1;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.cmd = hcsu_pkg::CMD_TRIAL;
        in_ch.strain_increment = '0;
        out_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.cmd, in_ch.strain_increment);
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.stress, out_ch.tangent, out_ch.on_reversal_branch);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_cycles = 600;
            out_ch.ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            out_ch.ready <= 0;
        end else begin
            out_ch.ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    task send_item(logic cmd, logic [31:0] de);
        while (!no_idle && $urandom_range(99) < 9) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.cmd <= cmd;
        in_ch.strain_increment <= de;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_reg(logic [hcsu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    function logic [31:0] pick_increment();
        int unsigned mode;
        logic [31:0] mag;
        if ($urandom_range(99) < 15) direction = -direction;
        mode = $urandom_range(99);
        if (mode < 10) return $urandom();
        if (mode < 20) mag = $urandom_range(16, 1);
        else if (mode < 60) mag = $urandom_range(32'h0010_0000);
        else mag = $urandom_range(32'h0800_0000);
        return (direction > 0) ? mag : -mag;
    endfunction

    task random_phase(int count);
        repeat (count) begin
            if ($urandom_range(99) < 35) send_item(hcsu_pkg::CMD_COMMIT, $urandom());
            else send_item(hcsu_pkg::CMD_TRIAL, pick_increment());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h7FFF_FFFF);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h8000_0000);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h0001_0000);
        send_item(hcsu_pkg::CMD_COMMIT, 32'hFFFF_FFFF);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h7FFF_FFFF);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h7FFF_FFFF);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'hFFFF_FFFF);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h8000_0000);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h8000_0000);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h4000_0000);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h0000_0001);
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS, 32'hFFFF_FFFF);
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS, 32'hFFFF_FFFF);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h7FFF_FFFF);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        send_item(hcsu_pkg::CMD_TRIAL, 32'h8000_0000);
        send_item(hcsu_pkg::CMD_COMMIT, 32'h0);
        random_phase(100);
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS, 32'd1);
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS, 32'd1);
        hold_req = 1;
        random_phase(110);
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS, 32'hFFFF_FFFF);
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS, 32'd1);
        no_idle = 1;
        random_phase(110);
        no_idle = 0;
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS, 32'd1);
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS, 32'hFFFF_FFFF);
        random_phase(110);
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS,
                  $urandom_range(32'h0100_0000, 32'h0000_1000));
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS,
                  $urandom_range(32'h0100_0000, 32'h0000_1000));
        random_phase(110);
        drain();

        write_reg(hcsu_pkg::CFG_MAX_SHEAR_MODULUS, $urandom() | 32'h1);
        write_reg(hcsu_pkg::CFG_MAX_SHEAR_STRESS, $urandom() | 32'h1);
        random_phase(110);
        drain();

        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/hcsu_pkg.sv
sv/hcsu_in_if.sv
sv/hcsu_out_if.sv
sv/hcsu_div.sv
sv/hcsu_ctrl.sv
sv/hcsu_dp.sv
sv/hyperbolic_cyclic_stress_update_unit.sv
tb/tb.sv
